// File: hdl/dma_descriptor_ring_engine_core_assert.svh
// Assertion macros used by the checker file of the descriptor ring engine.
// Plain text macros only; no dependencies.
`ifndef DMA_DESCRIPTOR_RING_ENGINE_CORE_ASSERT_SVH
`define DMA_DESCRIPTOR_RING_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DDER_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dder: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define DDER_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dder: next-cycle check failed");

// Implication that is checked in and around reset as well.
`define DDER_ASSERT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("dder: reset check failed");

`endif

// File: hdl/dder_pkg.sv
// Shared types and constants of the descriptor ring engine.
// No dependencies; used by the core and its checker.
package dder_pkg;

  // Default sizes of the ring storage.
  localparam int CHANNELS_DEF   = 4;
  localparam int RING_DEPTH_DEF = 128;

  // Configuration register.
  localparam int              CFG_W             = 8;
  localparam logic [CFG_W-1:0] RING_LENGTH_RESET = 8'd128;
  localparam int              RING_LENGTH_MIN   = 2;

  // Commands.
  localparam logic CMD_SUBMIT  = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_BUSY    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY   = 2'd3;

  // Operation kinds.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_COPY  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FINISH
  } dder_state_t;

  // One request beat.
  typedef struct packed {
    logic        command;
    logic [2:0]  channel_number;
    logic [47:0] source_address;
    logic [47:0] destination_address;
    logic [31:0] copy_length;
    logic        want_callback;
    logic [47:0] notify_address;
    logic [47:0] notify_value;
    logic [15:0] cpu_id;
  } dder_req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  operation_kind;
    logic [47:0] op_source;
    logic [47:0] op_target;
    logic [47:0] op_amount;
    logic        raise_interrupt;
    logic [15:0] interrupt_target;
  } dder_rsp_t;

  // One descriptor slot as held in the ring memory.
  typedef struct packed {
    logic [1:0]  kind;
    logic        raise;
    logic [15:0] cpu;
    logic [47:0] source;
    logic [47:0] target;
    logic [47:0] amount;
  } dder_slot_t;

endpackage

// File: hdl/dma_descriptor_ring_engine_core.sv
// Descriptor ring engine core: per-channel head/tail, ring memory, sequencer.
// Depends on dder_pkg.
//
// The block takes a new command beat only once the result of the last one
// is loaded into the output register, as the single-port descriptor memory
// may have to write two slots for a submit. A result beat is built in the
// finish step and sits in an output register, so the next request is taken
// while it waits. The ring memory has no reset and needs no clearing pass:
// slot data reaches a result only after the slot was written. cfg_ready is
// always high; write ring_length only while no command is in flight.
module dma_descriptor_ring_engine_core #(
  parameter int CHANNELS   = dder_pkg::CHANNELS_DEF,
  parameter int RING_DEPTH = dder_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  dder_pkg::dder_req_t         req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output dder_pkg::dder_rsp_t         rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dder_pkg::CFG_W-1:0]  cfg_data
);
  import dder_pkg::*;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int LEN_W  = $clog2(RING_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int SUM_W  = IDX_W + 2;
  localparam int SLOTS  = CHANNELS * RING_DEPTH;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Step a ring index, wrapping at the effective length.
  function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] i,
                                                    input logic [LEN_W-1:0] len);
    logic [IDX_W:0] inc;
    inc = {1'b0, i} + (IDX_W+1)'(1);
    return (inc >= (IDX_W+1)'(len)) ? '0 : inc[IDX_W-1:0];
  endfunction

  // Registers.
  dder_state_t       state, state_next;
  dder_req_t         req_q;
  logic [CFG_W-1:0]  ring_length;
  logic [IDX_W-1:0]  head [CHANNELS];
  logic [IDX_W-1:0]  tail [CHANNELS];
  dder_slot_t        mem [SLOTS];
  dder_slot_t        rd_slot;
  logic [1:0]        res_status;
  logic              res_from_mem;
  logic              wr2_pending;
  logic [ADDR_W-1:0] wr2_addr;

  // Combinational signals.
  logic              req_take;
  logic              rsp_load;
  logic [CMP_W-1:0]  len_wide;
  logic [LEN_W-1:0]  eff_len;
  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [IDX_W-1:0]  h, t, h1, h2, t1;
  logic              want_two;
  logic [SUM_W-1:0]  h_sum, t_ext;
  logic              room, empty;
  logic [ADDR_W-1:0] base, addr_h, addr_h1, addr_t;
  logic              is_submit;
  logic              submit_ok, service_ok;
  dder_slot_t        copy_slot, second_slot;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  dder_slot_t        mem_wdata;
  dder_rsp_t         rsp_next;

  assign cfg_ready = 1'b1;

  // Ring length clamped to the legal range.
  always_comb begin
    len_wide = CMP_W'(ring_length);
    if (len_wide < CMP_W'(RING_LENGTH_MIN)) begin
      eff_len = LEN_W'(RING_LENGTH_MIN);
    end else if (len_wide > CMP_W'(RING_DEPTH)) begin
      eff_len = LEN_W'(RING_DEPTH);
    end else begin
      eff_len = LEN_W'(len_wide);
    end
  end

  // Decode of the held request against the channel's head and tail.
  always_comb begin
    ch_ok      = {1'b0, req_q.channel_number} < 4'(CHANNELS);
    ch_idx     = req_q.channel_number[CH_W-1:0];
    h          = head[ch_idx];
    t          = tail[ch_idx];
    is_submit  = (req_q.command == CMD_SUBMIT);
    want_two   = req_q.want_callback || (req_q.notify_address != '0);
    h1         = ring_advance(h, eff_len);
    h2         = ring_advance(h1, eff_len);
    t1         = ring_advance(t, eff_len);
    h_sum      = SUM_W'(h) + (want_two ? SUM_W'(2) : SUM_W'(1));
    t_ext      = (t <= h) ? SUM_W'(t) + SUM_W'(eff_len) : SUM_W'(t);
    room       = h_sum < t_ext;
    empty      = (h == t);
    submit_ok  = ch_ok && is_submit && room;
    service_ok = ch_ok && !is_submit && !empty;
    base       = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH);
    addr_h     = base + ADDR_W'(h);
    addr_h1    = base + ADDR_W'(h1);
    addr_t     = base + ADDR_W'(t);
  end

  // Descriptor images written to the ring.
  always_comb begin
    copy_slot        = '0;
    copy_slot.kind   = OP_COPY;
    copy_slot.source = req_q.source_address;
    copy_slot.target = req_q.destination_address;
    copy_slot.amount = 48'(req_q.copy_length);
    second_slot      = '0;
    if (req_q.want_callback) begin
      second_slot.kind  = OP_NONE;
      second_slot.raise = 1'b1;
      second_slot.cpu   = req_q.cpu_id;
    end else begin
      second_slot.kind   = OP_WRITE;
      second_slot.target = req_q.notify_address;
      second_slot.amount = req_q.notify_value;
    end
  end

  // Result image built in the finish step.
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = res_status;
    if (res_from_mem) begin
      rsp_next.operation_kind  = rd_slot.kind;
      rsp_next.op_source       = rd_slot.source;
      rsp_next.op_target       = rd_slot.target;
      rsp_next.op_amount       = rd_slot.amount;
      rsp_next.raise_interrupt = rd_slot.raise;
      rsp_next.interrupt_target = rd_slot.raise ? rd_slot.cpu : '0;
    end
  end

  // Sequencer: next state, handshake and memory port control.
  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    req_stall  = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = addr_t;
    mem_wdata  = copy_slot;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_EVAL: begin
        state_next = S_FINISH;
        if (is_submit) begin
          mem_addr = addr_h;
          mem_we   = submit_ok;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_FINISH: begin
        mem_addr  = wr2_addr;
        mem_wdata = second_slot;
        mem_we    = wr2_pending;
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          req_stall  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    req_take = req_valid && !req_stall;
    if (req_take) begin
      state_next = S_EVAL;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= RING_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ring_length <= cfg_data;
    end
  end

  // Head and tail pointers, updated in the evaluate step.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else if (state == S_EVAL) begin
      if (submit_ok) begin
        head[ch_idx] <= want_two ? h2 : h1;
      end
      if (service_ok) begin
        tail[ch_idx] <= t1;
      end
    end
  end

  // Evaluate-step results carried into the finish step.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr2_pending <= 1'b0;
    end else if (state == S_EVAL) begin
      wr2_pending <= submit_ok && want_two;
    end else begin
      wr2_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      wr2_addr     <= addr_h1;
      res_from_mem <= service_ok;
      if (!ch_ok) begin
        res_status <= STATUS_INVALID;
      end else if (is_submit) begin
        res_status <= room ? STATUS_OK : STATUS_BUSY;
      end else begin
        res_status <= empty ? STATUS_EMPTY : STATUS_OK;
      end
    end
  end

  // Single-port descriptor memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_slot <= mem[mem_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hdl/dder_checker.sv
// Port-level checker for the descriptor ring engine core, with its bind.
// Depends on dder_pkg and dma_descriptor_ring_engine_core_assert.svh.
`include "dma_descriptor_ring_engine_core_assert.svh"

module dder_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input dder_pkg::dder_rsp_t rsp
);
  import dder_pkg::*;

  // After reset the core is empty and ready for a request.
  `DDER_ASSERT_RAW(a_reset_idle, clk, !rst && $past(rst), !rsp_valid && !req_stall)

  // An accepted request holds off a new one in the cycle after it.
  `DDER_ASSERT_NEXT(a_accept_locks, clk, rst, req_valid && !req_stall, req_stall)

  // A fresh result beat always follows an accepted request.
  `DDER_ASSERT_IMPL(a_rsp_after_req, clk, rst, $rose(rsp_valid),
    $past(req_valid && !req_stall, 3))

  // A failed or empty result carries no operation and no interrupt.
  `DDER_ASSERT_IMPL(a_fail_no_op, clk, rst, rsp_valid && (rsp.status != STATUS_OK),
    (rsp.operation_kind == OP_NONE) && !rsp.raise_interrupt && (rsp.op_amount == '0))

  // A stalled result beat holds.
  `DDER_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
    rsp_valid && $stable(rsp))

endmodule

bind dma_descriptor_ring_engine_core dder_checker u_dder_checker (.*);
